[src/flyrmp_pkg.sv]
`default_nettype none
package flyrmp_pkg;

	localparam int DUTY_W  = 12;
	localparam int TRIM_W  = 8;
	localparam int SPEED_W = 14;
	localparam int CNT_W   = 11;

	// configuration register indexes
	localparam logic [2:0] REG_BASE_PWM     = 3'd0;
	localparam logic [2:0] REG_SPEED_GOAL   = 3'd1;
	localparam logic [2:0] REG_ADAPT_GAIN   = 3'd2;
	localparam logic [2:0] REG_STEP_LIMIT   = 3'd3;
	localparam logic [2:0] REG_TRIM_LIMIT   = 3'd4;
	localparam logic [2:0] REG_RAMP_STEP    = 3'd5;
	localparam logic [2:0] REG_RC_DELAY     = 3'd6;
	localparam logic [2:0] REG_KEY_DELAY    = 3'd7;

	// register reset values
	localparam logic [9:0]  RST_BASE_PWM     = 10'd640;
	localparam logic [13:0] RST_SPEED_GOAL   = 14'd6272;
	localparam logic [3:0]  RST_ADAPT_GAIN   = 4'd2;
	localparam logic [3:0]  RST_STEP_LIMIT   = 4'd4;
	localparam logic [6:0]  RST_TRIM_LIMIT   = 7'd40;
	localparam logic [5:0]  RST_RAMP_STEP    = 6'd2;
	localparam logic [10:0] RST_RC_DELAY     = 11'd1000;
	localparam logic [10:0] RST_KEY_DELAY    = 11'd1250;

	// ramp within this many counts of the target counts as ready
	localparam logic [12:0] READY_WINDOW = 13'd20;

	typedef struct packed {
		logic [9:0]  base_pwm;
		logic [13:0] speed_goal;
		logic [3:0]  adapt_gain;
		logic [3:0]  adapt_step_limit;
		logic [6:0]  trim_limit;
		logic [5:0]  ramp_step;
		logic [10:0] rc_delay;
		logic [10:0] key_delay;
	} cfg_t;

	typedef struct packed {
		logic               key_mode;
		logic               rc_toggle;
		logic               shooter_powered;
		logic [SPEED_W-1:0] shot_speed;
	} tick_t;

	typedef struct packed {
		logic signed [DUTY_W-1:0] pwm_duty;
		logic                     wheel_on;
		logic                     ready_res;
		logic signed [TRIM_W-1:0] trim;
	} res_t;

endpackage
`default_nettype wire

[src/flyrmp_trim.sv]
`default_nettype none
module flyrmp_trim import flyrmp_pkg::*; (
	input  wire cfg_t                      cfg,
	input  wire logic [SPEED_W-1:0]        speed,
	input  wire logic [SPEED_W-1:0]        prev_speed,
	input  wire logic signed [TRIM_W-1:0]  trim_cur,
	output logic signed [TRIM_W-1:0]       trim_nxt
);

	logic signed [SPEED_W:0]   err;
	logic                      err_neg;
	logic [SPEED_W-1:0]        err_mag;
	logic [SPEED_W+3:0]        prod_mag;
	logic [11:0]               lim;
	logic [11:0]               clamp_mag;
	logic signed [TRIM_W:0]    delta;
	logic signed [TRIM_W:0]    sum;
	logic signed [TRIM_W:0]    tl;

	always_comb begin
		err       = $signed({1'b0, cfg.speed_goal}) - $signed({1'b0, speed});
		err_neg   = err[SPEED_W];
		err_mag   = err_neg ? SPEED_W'(-err) : err[SPEED_W-1:0];
		prod_mag  = (SPEED_W+4)'(err_mag) * (SPEED_W+4)'(cfg.adapt_gain);
		lim       = {cfg.adapt_step_limit, 8'd0};
		// clamp magnitude, then drop the fraction: truncates toward zero
		clamp_mag = (prod_mag > (SPEED_W+4)'(lim)) ? lim : prod_mag[11:0];
		delta     = err_neg ? -$signed({5'd0, clamp_mag[11:8]})
		                    :  $signed({5'd0, clamp_mag[11:8]});
		sum       = $signed({trim_cur[TRIM_W-1], trim_cur}) + delta;
		tl        = $signed({2'b00, cfg.trim_limit});
		if (sum > tl)
			sum = tl;
		else if (sum < -tl)
			sum = -tl;
		trim_nxt  = (speed != prev_speed) ? sum[TRIM_W-1:0] : trim_cur;
	end

endmodule
`default_nettype wire

[src/flyrmp_ctrl.sv]
`default_nettype none
module flyrmp_ctrl import flyrmp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  step,
	input  wire tick_t tick,
	output res_t       res
);

	logic                       running_q;
	logic signed [DUTY_W-1:0]   ramp_q;
	logic signed [TRIM_W-1:0]   trim_q;
	logic [SPEED_W-1:0]         prev_speed_q;
	logic [CNT_W-1:0]           rc_cnt_q;
	logic [CNT_W-1:0]           key_cnt_q;

	logic                       running_nxt;
	logic signed [DUTY_W-1:0]   ramp_base;
	logic [CNT_W-1:0]           rc_cnt_nxt;
	logic [CNT_W-1:0]           key_cnt_nxt;
	logic signed [TRIM_W-1:0]   trim_nxt;
	logic signed [DUTY_W:0]     target;
	logic signed [DUTY_W:0]     ramp_ext;
	logic signed [DUTY_W:0]     rstep;
	logic signed [DUTY_W:0]     ramp_new;
	logic signed [DUTY_W:0]     gap_abs;

	flyrmp_trim u_trim (
		.cfg        (cfg),
		.speed      (tick.shot_speed),
		.prev_speed (prev_speed_q),
		.trim_cur   (trim_q),
		.trim_nxt   (trim_nxt)
	);

	always_comb begin
		running_nxt = running_q;
		ramp_base   = ramp_q;
		rc_cnt_nxt  = rc_cnt_q;
		key_cnt_nxt = key_cnt_q;
		if (!tick.key_mode) begin
			if (rc_cnt_q < cfg.rc_delay) begin
				rc_cnt_nxt  = rc_cnt_q + 1'b1;
				running_nxt = 1'b0;
				ramp_base   = '0;
			end else if (tick.rc_toggle) begin
				running_nxt = !running_q;
			end
		end else if (tick.shooter_powered) begin
			if (key_cnt_q < cfg.key_delay) begin
				key_cnt_nxt = key_cnt_q + 1'b1;
				running_nxt = 1'b0;
			end else begin
				running_nxt = 1'b1;
			end
		end else begin
			running_nxt = 1'b0;
			ramp_base   = '0;
			key_cnt_nxt = '0;
		end

		target   = running_nxt ? $signed({3'b000, cfg.base_pwm})
		                         + $signed({{(DUTY_W+1-TRIM_W){trim_nxt[TRIM_W-1]}}, trim_nxt})
		                       : '0;
		ramp_ext = $signed({ramp_base[DUTY_W-1], ramp_base});
		rstep    = $signed({7'd0, cfg.ramp_step});
		ramp_new = ramp_ext;
		if (ramp_ext < target) begin
			ramp_new = ramp_ext + rstep;
			if (ramp_new > target)
				ramp_new = target;
		end else if (ramp_ext > target) begin
			ramp_new = ramp_ext - rstep;
			if (ramp_new < target)
				ramp_new = target;
		end
		gap_abs = target - ramp_new;
		if (gap_abs < 0)
			gap_abs = -gap_abs;

		res.pwm_duty  = ramp_new[DUTY_W-1:0];
		res.wheel_on  = running_nxt;
		res.ready_res = running_nxt && ($unsigned(gap_abs) <= READY_WINDOW);
		res.trim      = trim_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			ramp_q       <= '0;
			trim_q       <= '0;
			prev_speed_q <= '0;
			rc_cnt_q     <= '0;
			key_cnt_q    <= '0;
		end else if (step) begin
			running_q    <= running_nxt;
			ramp_q       <= ramp_new[DUTY_W-1:0];
			trim_q       <= trim_nxt;
			prev_speed_q <= tick.shot_speed;
			rc_cnt_q     <= rc_cnt_nxt;
			key_cnt_q    <= key_cnt_nxt;
		end
	end

	a_rc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !tick.key_mode && rc_cnt_q < cfg.rc_delay) |=> (ramp_q == 0 && !running_q))
		else $error("ramp or run state not cleared during power-up delay");

	a_key_off: assert property (@(posedge clk) disable iff (!arst_n)
		(step && tick.key_mode && !tick.shooter_powered)
		|=> (key_cnt_q == 0 && ramp_q == 0 && !running_q))
		else $error("key mode did not reset on power loss");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(ramp_q) && $stable(trim_q) && $stable(running_q)))
		else $error("state moved without a tick");

	a_ready_on: assert property (@(posedge clk) disable iff (!arst_n)
		res.ready_res |-> res.wheel_on)
		else $error("ready flagged while wheels off");

endmodule
`default_nettype wire

[src/flywheel_ramp_with_speed_trim_core.sv]
`default_nettype none
// Flywheel duty ramp with adaptive projectile-speed trim.
// Path: an input register captures each accepted word, then one registered update of
// control state and result makes its result word valid.
// Throughput: one word per cycle while the result stream is not stalled (m_tready low).
// Reset (arst_n low, asynchronous): control state, counters and trim clear to 0,
// configuration registers return to their defaults, both stages empty.
module flywheel_ramp_with_speed_trim_core import flyrmp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [13:0] cfg_wdata,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [0] rc_toggle, [1] shooter_powered, [15:2] shot_speed
	input  wire logic        s_tuser,   // [0] key_mode
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // [11:0] pwm_duty, [12] wheel_on, [13] ready_res,
	                                    // [21:14] trim, [23:22] zero
);

	cfg_t  cfg_q;
	tick_t tick_s1;
	logic  vld_s1;
	res_t  res_s2;
	logic  vld_s2;
	res_t  res_nxt;
	logic  step;

	// Hold configuration; a write lands at any edge with cfg_we high, so write only while idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_pwm         <= RST_BASE_PWM;
			cfg_q.speed_goal       <= RST_SPEED_GOAL;
			cfg_q.adapt_gain       <= RST_ADAPT_GAIN;
			cfg_q.adapt_step_limit <= RST_STEP_LIMIT;
			cfg_q.trim_limit       <= RST_TRIM_LIMIT;
			cfg_q.ramp_step        <= RST_RAMP_STEP;
			cfg_q.rc_delay         <= RST_RC_DELAY;
			cfg_q.key_delay        <= RST_KEY_DELAY;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BASE_PWM:     cfg_q.base_pwm         <= cfg_wdata[9:0];
				REG_SPEED_GOAL:   cfg_q.speed_goal       <= cfg_wdata;
				REG_ADAPT_GAIN:   cfg_q.adapt_gain       <= cfg_wdata[3:0];
				REG_STEP_LIMIT:   cfg_q.adapt_step_limit <= cfg_wdata[3:0];
				REG_TRIM_LIMIT:   cfg_q.trim_limit       <= cfg_wdata[6:0];
				REG_RAMP_STEP:    cfg_q.ramp_step        <= cfg_wdata[5:0];
				REG_RC_DELAY:     cfg_q.rc_delay         <= cfg_wdata[10:0];
				REG_KEY_DELAY:    cfg_q.key_delay        <= cfg_wdata[10:0];
				default:          cfg_q                  <= cfg_q;
			endcase
		end
	end

	// Advance the held tick whenever the result register is free or being drained.
	assign step     = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			tick_s1.key_mode        <= s_tuser;
			tick_s1.rc_toggle       <= s_tdata[0];
			tick_s1.shooter_powered <= s_tdata[1];
			tick_s1.shot_speed      <= s_tdata[15:2];
		end
	end

	// Update mode, counters, trim and ramp for the held tick.
	flyrmp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (step),
		.tick   (tick_s1),
		.res    (res_nxt)
	);

	// Result register: keeps the finished word while the next tick waits in stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (step) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {2'b00, res_s2.trim, res_s2.ready_res, res_s2.wheel_on, res_s2.pwm_duty};

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !m_tready) |=> (vld_s2 && $stable(res_s2)))
		else $error("pending result lost under stall");

	a_step_fill: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> vld_s2)
		else $error("processed tick produced no result");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !step) |=> (vld_s1 && $stable(tick_s1)))
		else $error("held tick dropped while result stalled");

endmodule
`default_nettype wire
